@@ hdl/aeap_pkg.sv @@
package aeap_pkg;

    localparam int CH_W         = 2;
    localparam int SAMPLE_W     = 10;
    localparam int GAIN_W       = 16;
    localparam int PROD_W       = GAIN_W + SAMPLE_W;
    localparam int ACC_W        = 32;
    localparam int PULSE_W      = 8;
    localparam int RC_W         = 10;
    localparam int MASK_W       = 3;
    localparam int NUM_GAINS    = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam int DEFAULT_CHANNELS = 3;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 72;
    localparam int M_TUSER_W    = CH_W;

    // power scaling
    localparam int MAG_HI_W     = 16;
    localparam int WATT_SHIFT   = 18;
    localparam int SCALED_W     = 2 * MAG_HI_W - WATT_SHIFT;
    localparam logic [MAG_HI_W-1:0] WATT_SCALE = 16'd61909;
    localparam int PP_W         = 20;
    localparam logic [11:0] PULSE_WATTS = 12'd3600;
    localparam int SUM_W        = PP_W + 1;

    localparam logic [CH_W-1:0]   RST_ANALOG_CHANNELS = 2'd3;
    localparam logic [MASK_W-1:0] RST_ENABLE_MASK     = 3'd0;
    localparam logic [ACC_W-1:0]  RST_UNIT_THRESHOLD  = 32'd1000000000;
    localparam logic [RC_W-1:0]   RST_TICKS_PER_SEC   = 10'd666;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANALOG_CHANNELS,
        REG_ENABLE_MASK,
        REG_GAIN_CH0,
        REG_GAIN_CH1,
        REG_GAIN_CH2,
        REG_UNIT_THRESHOLD,
        REG_TICKS_PER_SECOND
    } cfg_index_t;

    typedef struct packed {
        logic [CH_W-1:0]                    analog_channels;
        logic [MASK_W-1:0]                  enable_mask;
        logic [NUM_GAINS-1:0][GAIN_W-1:0]   gain;
        logic [ACC_W-1:0]                   unit_threshold;
        logic [RC_W-1:0]                    ticks_per_second;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0]     ch;
        logic                used;
        logic                rc_zero;
        logic                rc_last;
        logic [SAMPLE_W-1:0] sample;
    } tick_t;

    typedef struct packed {
        logic [ACC_W-1:0] power_watts;
        logic             power_valid;
        logic             unit_pulse;
        logic [ACC_W-1:0] energy_count;
        logic             sample_used;
        logic [CH_W-1:0]  channel;
    } result_t;

endpackage

@@ hdl/aeap_front.sv @@
module aeap_front #(
    parameter int CHANNELS = aeap_pkg::DEFAULT_CHANNELS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  aeap_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [aeap_pkg::SAMPLE_W-1:0] in_sample,
    output logic                          push_valid,
    input  logic                          push_ready,
    output aeap_pkg::tick_t               push_tick
);
    import aeap_pkg::*;

    logic [CH_W-1:0] ch_reg, ch_next;
    logic [RC_W-1:0] rc_reg, rc_next;
    logic [RC_W:0]   rc_inc;
    logic            last_ch;
    logic            mask_bit;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    always_comb
    begin
        last_ch  = (ch_reg == CH_W'(CHANNELS - 1));
        mask_bit = |(cfg.enable_mask & (MASK_W'(1) << ch_reg));
        ch_next  = last_ch ? '0 : ch_reg + CH_W'(1);
        rc_inc   = last_ch ? ({1'b0, rc_reg} + (RC_W+1)'(1)) : {1'b0, rc_reg};
        rc_next  = (rc_inc > {1'b0, cfg.ticks_per_second}) ? '0 : rc_inc[RC_W-1:0];

        push_tick.ch      = ch_reg;
        push_tick.used    = (ch_reg < cfg.analog_channels) && mask_bit;
        push_tick.rc_zero = (rc_reg == '0);
        push_tick.rc_last = (rc_reg == cfg.ticks_per_second);
        push_tick.sample  = in_sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg <= '0;
            rc_reg <= '0;
        end
        else if (in_valid && push_ready)
        begin
            ch_reg <= ch_next;
            rc_reg <= rc_next;
        end
    end

endmodule

@@ hdl/aeap_fifo.sv @@
module aeap_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  aeap_pkg::tick_t push_tick,
    output logic            pop_valid,
    input  logic            pop_ready,
    output aeap_pkg::tick_t pop_tick
);
    import aeap_pkg::*;

    tick_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_tick   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_tick;
    end

endmodule

@@ hdl/aeap_back.sv @@
module aeap_back #(
    parameter int CHANNELS = aeap_pkg::DEFAULT_CHANNELS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  aeap_pkg::cfg_t    cfg,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  aeap_pkg::tick_t   pop_tick,
    output logic              res_valid,
    input  logic              res_ready,
    output aeap_pkg::result_t res
);
    import aeap_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // per-channel state
    logic [ACC_W-1:0]   acc_reg  [CHANNELS];
    logic [ACC_W-1:0]   eng_reg  [CHANNELS];
    logic [PULSE_W-1:0] pls_reg  [CHANNELS];
    logic [ACC_W-1:0]   end_reg  [CHANNELS];
    logic               lock_reg [CHANNELS];

    // accumulate stage
    logic [IDX_W-1:0]   idx;
    logic [GAIN_W-1:0]  gain_sel;
    logic [PROD_W-1:0]  product;
    logic [ACC_W-1:0]   acc_sum, acc_next, eng_next, diff_next;
    logic [PULSE_W-1:0] pls_inc;
    logic               unit, lock_cur, snap, pop_fire;

    // stage registers
    logic               p1_valid_reg, p2_valid_reg, out_valid_reg;
    logic               p1_ready, p2_ready, out_ready;
    logic [CH_W-1:0]    p1_ch_reg, p2_ch_reg;
    logic               p1_used_reg, p2_used_reg;
    logic [ACC_W-1:0]   p1_eng_reg, p2_eng_reg;
    logic               p1_unit_reg, p2_unit_reg;
    logic               p1_pv_reg, p2_pv_reg;
    logic [ACC_W-1:0]   p1_diff_reg;
    logic [PULSE_W-1:0] p1_pls_reg;
    logic               p2_neg_reg;
    logic [MAG_HI_W-1:0] p2_mag_reg;
    logic [PP_W-1:0]    p2_pp_reg;
    result_t            res_reg, res_next;

    logic [ACC_W-1:0]      mag;
    logic [2*MAG_HI_W-1:0] scaled_full;
    logic [SCALED_W-1:0]   scaled;
    logic [SUM_W-1:0]      watts_sum;

    assign out_ready = !out_valid_reg || res_ready;
    assign p2_ready  = !p2_valid_reg || out_ready;
    assign p1_ready  = !p1_valid_reg || p2_ready;
    assign pop_ready = p1_ready;
    assign pop_fire  = pop_valid && p1_ready;
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        idx = pop_tick.ch[IDX_W-1:0];
        case (pop_tick.ch)
            2'd0:    gain_sel = cfg.gain[0];
            2'd1:    gain_sel = cfg.gain[1];
            2'd2:    gain_sel = cfg.gain[2];
            default: gain_sel = '0;
        endcase
        product   = gain_sel * pop_tick.sample;
        acc_sum   = acc_reg[idx] + ACC_W'(product);
        unit      = (acc_sum >= cfg.unit_threshold);
        acc_next  = unit ? (acc_sum - cfg.unit_threshold) : acc_sum;
        eng_next  = eng_reg[idx] + ACC_W'(unit);
        pls_inc   = pls_reg[idx] + PULSE_W'(unit);
        lock_cur  = pop_tick.rc_zero ? 1'b0 : lock_reg[idx];
        snap      = pop_tick.rc_last && !lock_cur;
        diff_next = acc_next - end_reg[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                acc_reg[i]  <= '0;
                eng_reg[i]  <= '0;
                pls_reg[i]  <= '0;
                end_reg[i]  <= '0;
                lock_reg[i] <= 1'b0;
            end
        end
        else if (pop_fire && pop_tick.used)
        begin
            acc_reg[idx]  <= acc_next;
            eng_reg[idx]  <= eng_next;
            pls_reg[idx]  <= snap ? '0 : pls_inc;
            lock_reg[idx] <= snap ? 1'b1 : lock_cur;
            if (snap)
                end_reg[idx] <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (p1_ready)
                p1_valid_reg <= pop_valid;
            if (p2_ready)
                p2_valid_reg <= p1_valid_reg;
            if (out_ready)
                out_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_ready)
        begin
            p1_ch_reg   <= pop_tick.ch;
            p1_used_reg <= pop_tick.used;
            p1_eng_reg  <= pop_tick.used ? eng_next : eng_reg[idx];
            p1_unit_reg <= pop_tick.used && unit;
            p1_pv_reg   <= pop_tick.used && snap;
            p1_diff_reg <= diff_next;
            p1_pls_reg  <= pls_inc;
        end
    end

    // magnitude and pulse term
    always_comb
    begin
        mag = p1_diff_reg[ACC_W-1] ? (ACC_W'(0) - p1_diff_reg) : p1_diff_reg;
    end

    always_ff @(posedge clk)
    begin
        if (p2_ready)
        begin
            p2_ch_reg   <= p1_ch_reg;
            p2_used_reg <= p1_used_reg;
            p2_eng_reg  <= p1_eng_reg;
            p2_unit_reg <= p1_unit_reg;
            p2_pv_reg   <= p1_pv_reg;
            p2_neg_reg  <= p1_diff_reg[ACC_W-1];
            p2_mag_reg  <= mag[ACC_W-1 -: MAG_HI_W];
            p2_pp_reg   <= PP_W'(p1_pls_reg) * PP_W'(PULSE_WATTS);
        end
    end

    // scale and combine
    always_comb
    begin
        scaled_full = p2_mag_reg * WATT_SCALE;
        scaled      = scaled_full[2*MAG_HI_W-1 -: SCALED_W];
        watts_sum   = SUM_W'(scaled) + SUM_W'(p2_pp_reg);

        res_next.channel      = p2_ch_reg;
        res_next.sample_used  = p2_used_reg;
        res_next.energy_count = p2_eng_reg;
        res_next.unit_pulse   = p2_unit_reg;
        res_next.power_valid  = p2_pv_reg;
        if (!p2_pv_reg)
            res_next.power_watts = '0;
        else if (!p2_neg_reg)
            res_next.power_watts = ACC_W'(watts_sum);
        else if (PP_W'(scaled) > p2_pp_reg)
            res_next.power_watts = '0;
        else
            res_next.power_watts = ACC_W'(p2_pp_reg - PP_W'(scaled));
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
            res_reg <= res_next;
    end

endmodule

@@ hdl/adc_energy_accumulator_power.sv @@
// channel | dir | tdata / tuser fields (lsb first)
// s_axis  | in  | tdata: adc_sample
// m_axis  | out | tdata: sample_used, energy_count, unit_pulse, power_valid, power_watts
//         |     | tuser: channel
// cfg     | in  | cfg_wr_en, cfg_index, cfg_data
// one sample accepted per cycle while the queue is not full; results follow the queue, back stage and output register
// per-channel accumulate, threshold compare and snapshot close happen together in the back stage
// power scaling runs in two further pipeline stages, an output register holds the result
// a two-entry queue between front and back; output stalls back up into s_axis_tready
// reset clears all channel state and loads the register defaults, no clearing pass
module adc_energy_accumulator_power #(
    parameter int CHANNELS = aeap_pkg::DEFAULT_CHANNELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [aeap_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // adc_sample
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // sample_used, energy_count, unit_pulse, power_valid, power_watts
    output logic [aeap_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic [aeap_pkg::M_TUSER_W-1:0]  m_axis_tuser,   // channel
    input  logic                            cfg_wr_en,
    input  logic [aeap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aeap_pkg::CFG_DATA_W-1:0] cfg_data
);
    import aeap_pkg::*;

    cfg_t    cfg_reg;
    tick_t   push_tick, pop_tick;
    logic    push_valid, push_ready, pop_valid, pop_ready;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.analog_channels  <= RST_ANALOG_CHANNELS;
            cfg_reg.enable_mask      <= RST_ENABLE_MASK;
            cfg_reg.gain             <= '0;
            cfg_reg.unit_threshold   <= RST_UNIT_THRESHOLD;
            cfg_reg.ticks_per_second <= RST_TICKS_PER_SEC;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                REG_ANALOG_CHANNELS:  cfg_reg.analog_channels  <= cfg_data[CH_W-1:0];
                REG_ENABLE_MASK:      cfg_reg.enable_mask      <= cfg_data[MASK_W-1:0];
                REG_GAIN_CH0:         cfg_reg.gain[0]          <= cfg_data[GAIN_W-1:0];
                REG_GAIN_CH1:         cfg_reg.gain[1]          <= cfg_data[GAIN_W-1:0];
                REG_GAIN_CH2:         cfg_reg.gain[2]          <= cfg_data[GAIN_W-1:0];
                REG_UNIT_THRESHOLD:   cfg_reg.unit_threshold   <= cfg_data[ACC_W-1:0];
                REG_TICKS_PER_SECOND: cfg_reg.ticks_per_second <= cfg_data[RC_W-1:0];
                default: ;
            endcase
        end
    end

    aeap_front #(
        .CHANNELS(CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_sample  (s_axis_tdata[SAMPLE_W-1:0]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_tick  (push_tick)
    );

    aeap_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_tick  (push_tick),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_tick   (pop_tick)
    );

    aeap_back #(
        .CHANNELS(CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_tick  (pop_tick),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tuser = res.channel;
    assign m_axis_tdata = M_TDATA_W'({res.power_watts, res.power_valid, res.unit_pulse,
                                      res.energy_count, res.sample_used});

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (res.unit_pulse || res.power_valid) |-> res.sample_used)
        else $error("unit or power flagged on an unused tick");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !res.power_valid |-> res.power_watts == '0)
        else $error("nonzero watts without power_valid");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> res.channel < CH_W'(CHANNELS))
        else $error("channel out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> pop_valid)
        else $error("queue empty after a transfer");

endmodule
